[design/ald_pkg.sv]
// Shared types and constants for the ambient light dimmer.
// Used by ald_ctrl, ald_dp and the ambient_light_dimmer top level.
`default_nettype none
package ald_pkg;

    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 2;
    localparam int SMP_W      = 12;
    localparam int PCT_W      = 7;
    localparam int DRV_W      = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_HIGH = 2'd1;

    localparam logic [1:0] ON_CMD_OFF      = 2'd1;
    localparam logic [1:0] ON_CMD_ON       = 2'd2;
    localparam logic [1:0] AUTO_CMD_MANUAL = 2'd1;
    localparam logic [1:0] AUTO_CMD_AUTO   = 2'd2;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [DRV_W-1:0] DRV_FULL = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_LWAIT = 4'b0100,
        S_DONE  = 4'b1000
    } ald_state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic apply_level;
        logic out_write;
    } ald_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } ald_status_t;

endpackage
`default_nettype wire

[design/ald_ctrl.sv]
// Sequencing state machine for the ambient light dimmer.
// Depends on ald_pkg; drives the commands of ald_dp.
`default_nettype none
module ald_ctrl
    import ald_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  ald_status_t      st,
    output ald_cmd_t         cmd
);

    ald_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = st.need_div ? S_LWAIT : S_DONE;
            end
            S_LWAIT: begin
                if (st.div_done) begin
                    cmd.apply_level = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/ald_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ald_pkg; instantiated by ald_dp.
`default_nettype none
module ald_div
    import ald_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = num;
            cnt_next  = CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = shifted[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

[design/ald_dp.sv]
// Datapath of the ambient light dimmer: mode state, window registers,
// brightness arithmetic and the result register. Depends on ald_pkg, ald_div.
`default_nettype none
module ald_dp
    import ald_pkg::*;
#(
    parameter int LEVEL_MAX     = 255,
    parameter int DEFAULT_LEVEL = 128,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  ald_cmd_t                   cmd,
    output ald_status_t                st,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int LW        = $clog2(LEVEL_MAX + 1);
    localparam int DEN_W     = SMP_W;
    localparam int NUM_W     = LW + SMP_W;
    localparam int HW        = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam int PCT_TAB_N = 2 ** PCT_W;
    localparam int LVL_TAB_N = 2 ** DRV_W;
    localparam logic [LW-1:0]    LVL_C   = LW'(LEVEL_MAX);
    localparam logic [DRV_W-1:0] LVL_SAT = (LEVEL_MAX > 255) ? DRV_FULL : DRV_W'(LEVEL_MAX);
    localparam logic [DRV_W-1:0] DEF_SAT =
        (DEFAULT_LEVEL > 255) ? DRV_FULL : DRV_W'(DEFAULT_LEVEL);

    logic [CFG_W-1:0] low_reg, high_reg;
    logic             pwr_reg, sub_reg;
    logic [DRV_W-1:0] level_reg;
    logic [HW-1:0]    held_reg;

    logic [1:0]       on_cmd_reg, auto_cmd_reg;
    logic             lvl_ok_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [SMP_W-1:0] smp_reg;

    logic             was_on_reg, fault_reg;
    logic             m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [DRV_W-1:0] pct_level [0:PCT_TAB_N-1];
    logic [PCT_W-1:0] level_pct [0:LVL_TAB_N-1];

    logic [SMP_W-1:0] smp_m, smp_lo, smp_cl;
    logic             win_bad;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0] div_den;
    logic [DRV_W-1:0] level_q;
    logic [DRV_W-1:0] drive;

    // Manual brightness per percent, with percents above 100 saturated.
    for (genvar g = 0; g < PCT_TAB_N; g++) begin : g_pct_level
        localparam int PCT_CAP = (g > 100) ? 100 : g;
        localparam int LVL_VAL = LEVEL_MAX * PCT_CAP / 100;
        assign pct_level[g] = (LVL_VAL > 255) ? DRV_FULL : DRV_W'(LVL_VAL);
    end

    // Status percent per stored brightness, saturated at 100.
    for (genvar g = 0; g < LVL_TAB_N; g++) begin : g_level_pct
        localparam int PCT_VAL = g * 100 / LEVEL_MAX;
        assign level_pct[g] = (PCT_VAL > 100) ? PCT_FULL : PCT_W'(PCT_VAL);
    end

    assign smp_m   = SMP_W'(smp_reg[HW-1:0]);
    assign smp_lo  = (smp_m < low_reg) ? low_reg : smp_m;
    assign smp_cl  = (smp_lo > high_reg) ? high_reg : smp_lo;
    assign win_bad = (high_reg <= low_reg);

    assign st.need_div = pwr_reg && sub_reg && !win_bad;
    assign st.div_done = div_done;
    assign st.out_free = !m_valid_reg || m_tready;

    assign div_start = cmd.eval && st.need_div;
    assign div_num   = NUM_W'(LVL_C) * NUM_W'(high_reg - smp_cl);
    assign div_den   = high_reg - low_reg;

    ald_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign level_q = (div_quot > NUM_W'(DRV_FULL)) ? DRV_FULL : div_quot[DRV_W-1:0];
    assign drive   = was_on_reg ? level_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg     <= '0;
            high_reg    <= '1;
            pwr_reg     <= 1'b1;
            sub_reg     <= 1'b1;
            level_reg   <= DEF_SAT;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == REG_SENSOR_LOW) begin
                low_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_SENSOR_HIGH) begin
                high_reg <= cfg_wdata;
            end
            if (cmd.eval) begin
                if (!pwr_reg) begin
                    if (on_cmd_reg == ON_CMD_ON) begin
                        pwr_reg <= 1'b1;
                        sub_reg <= 1'b0;
                    end
                end else begin
                    if (!sub_reg) begin
                        if (lvl_ok_reg) begin
                            level_reg <= pct_level[pct_reg];
                        end
                        if (auto_cmd_reg == AUTO_CMD_AUTO) begin
                            sub_reg <= 1'b1;
                        end
                    end else begin
                        held_reg <= smp_reg[HW-1:0];
                        if (win_bad) begin
                            level_reg <= LVL_SAT;
                        end
                        if (auto_cmd_reg == AUTO_CMD_MANUAL) begin
                            sub_reg <= 1'b0;
                        end
                    end
                    if (on_cmd_reg == ON_CMD_OFF) begin
                        pwr_reg <= 1'b0;
                    end
                end
            end
            if (cmd.apply_level) begin
                level_reg <= level_q;
            end
            if (cmd.out_write) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            on_cmd_reg   <= s_tdata[1:0];
            auto_cmd_reg <= s_tdata[3:2];
            pct_reg      <= s_tdata[10:4];
            smp_reg      <= s_tdata[22:11];
            lvl_ok_reg   <= s_tuser;
        end
        if (cmd.eval) begin
            was_on_reg <= pwr_reg;
            fault_reg  <= pwr_reg && sub_reg && win_bad;
        end
        if (cmd.out_write) begin
            m_data_reg <= {2'b00, fault_reg, SMP_W'(held_reg), level_pct[level_reg],
                           sub_reg, pwr_reg, drive};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

[design/ambient_light_dimmer.sv]
// Ambient light dimmer: on/off and manual/auto modes for one LED.
// Top level; depends on ald_pkg, ald_ctrl, ald_dp (which uses ald_div).
//
// Each request on the s_ channel is one control tick carrying the on and
// auto commands, a manual percent and a light-sensor sample. Each tick
// returns exactly one request on the m_ channel with the LED drive, the
// modes, the shown percent, the held sample and the window fault flag.
// The sensor window registers are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while no tick is in flight, and the block
// itself does not enforce this. One tick is worked at a time. An automatic
// tick over a valid sensor window runs the serial divider, one quotient bit
// per cycle, over NUM_W bits, where NUM_W is the bit width of LEVEL_MAX plus
// 12; its result is loaded into the level register and then into the output
// register. Every other tick goes from acceptance through evaluation straight
// to the output register; the manual and shown percents come from constant
// tables. The next tick is accepted only once the output register is written.
// The next tick may be accepted while a finished result still waits in the
// output register; a stalled receiver holds the result and blocks completion
// of the following tick. Reset puts the light on in automatic mode with the
// default brightness, a full sensor window and an empty output register.
`default_nettype none
module ambient_light_dimmer
    import ald_pkg::*;
#(
    parameter int LEVEL_MAX     = 255,
    parameter int DEFAULT_LEVEL = 128,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // on_command[1:0], auto_command[3:2], level_percent[10:4],
    // sensor_sample[22:11], zero fill[23].
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // level_valid[0].
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // light_drive[7:0], power_on[8], auto_mode[9], shown_percent[16:10],
    // last_sample[28:17], window_fault[29], zero fill[31:30].
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    ald_cmd_t    cmd;
    ald_status_t st;

    ald_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ald_dp #(
        .LEVEL_MAX     (LEVEL_MAX),
        .DEFAULT_LEVEL (DEFAULT_LEVEL),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
